[rtl/ept_pkg.sv]
// shared types, codes and constants of the endless pot position tracker
package ept_pkg;

  // default widths
  localparam int DEFAULT_ADC_BITS      = 12;
  localparam int DEFAULT_POSITION_BITS = 16;

  // configuration register index width and reset values
  localparam int CFG_INDEX_BITS       = 3;
  localparam int THRESHOLD_RESET      = 10;
  localparam int FULL_SCALE_RESET     = 1023;
  localparam int DIVISOR_RESET        = 1;
  localparam int FLOOR_RESET          = 0;
  localparam int CEILING_RESET        = 1023;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MOVE_THRESHOLD   = 3'd0,
    CFG_ADC_FULL_SCALE   = 3'd1,
    CFG_STEP_DIVISOR     = 3'd2,
    CFG_POSITION_FLOOR   = 3'd3,
    CFG_POSITION_CEILING = 3'd4
  } cfg_reg_t;

  // turn direction codes
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } turn_dir_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_FINISH
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;
    logic prep;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
  } dp_status_t;

endpackage

[rtl/ept_in_if.sv]
// sample pair channel: valid, ready and the two wiper samples
interface ept_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] wiper_a;
  logic [ADC_BITS-1:0] wiper_b;

  modport source (output valid, output wiper_a, output wiper_b, input ready);
  modport sink   (input valid, input wiper_a, input wiper_b, output ready);
endinterface

[rtl/ept_out_if.sv]
// result channel: valid, ready, position, direction and moving flag
interface ept_out_if #(
  parameter int POSITION_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] position;
  logic [1:0]                      turn_direction;
  logic                            moving;

  modport source (output valid, output position, output turn_direction, output moving,
                  input ready);
  modport sink   (input valid, input position, input turn_direction, input moving,
                  output ready);
endinterface

[rtl/endless_pot_position_tracker_core.sv]
// Endless pot position tracker: top level joining controller and datapath.
//
// Usage: sample_in carries one pair of wiper samples per transfer (valid/ready);
// result_out returns exactly one result per sample: the clamped position, the
// turn direction and the moving flag. Configuration is written through the
// plain write port (cfg_write, cfg_index, cfg_data); the user must write it only
// while the block is idle, and the block itself does not enforce this. Indexes beyond the
// register list are ignored.
// Flow: a sample is captured on its input transfer, then classified and loaded
// into the restoring divider, then divided bit by bit, and then committed. The
// controller returns to idle before it takes the next sample, and one sample is
// in work at a time, so a new sample is not taken before the last one is
// committed.
// Stall: the result sits in an output register; a new sample is taken while it
// waits, and the commit of that sample holds until the register is free.
// Reset (rst, synchronous): previous wipers and position clear to zero, the
// configuration registers return to their defaults, no result is pending.
module endless_pot_position_tracker_core
  import ept_pkg::*;
#(
  parameter int ADC_BITS      = DEFAULT_ADC_BITS,
  parameter int POSITION_BITS = DEFAULT_POSITION_BITS,
  parameter int CFG_BITS      = (ADC_BITS > POSITION_BITS) ? ADC_BITS : POSITION_BITS
)(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  ept_in_if.sink                    sample_in,
  ept_out_if.source                 result_out
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  ept_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // arithmetic and state
  ept_datapath #(
    .ADC_BITS      (ADC_BITS),
    .POSITION_BITS (POSITION_BITS),
    .CFG_BITS      (CFG_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .wiper_a        (sample_in.wiper_a),
    .wiper_b        (sample_in.wiper_b),
    .cmd            (cmd),
    .status         (status),
    .position       (result_out.position),
    .turn_direction (result_out.turn_direction),
    .moving         (result_out.moving)
  );

endmodule

[rtl/ept_ctrl.sv]
// controller state machine: sequences capture, divide and commit of one sample
module ept_ctrl
  import ept_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid & ~out_ready;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // commit only when the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // input transfer always starts the prepare step
  a_take_to_prep: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_PREP))
    else $error("input transfer not followed by prepare");

  // a new result only appears after a commit
  a_rise_after_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result valid without commit");

  // last divide step leads to commit
  a_div_to_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && status.div_last) |=> (state == S_FINISH))
    else $error("divider end not followed by commit");

endmodule

[rtl/ept_datapath.sv]
// datapath: configuration, wiper classification, serial divider and clamped accumulator
module ept_datapath
  import ept_pkg::*;
#(
  parameter int ADC_BITS      = DEFAULT_ADC_BITS,
  parameter int POSITION_BITS = DEFAULT_POSITION_BITS,
  parameter int CFG_BITS      = (ADC_BITS > POSITION_BITS) ? ADC_BITS : POSITION_BITS
)(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [CFG_BITS-1:0]             cfg_data,
  input  logic [ADC_BITS-1:0]             wiper_a,
  input  logic [ADC_BITS-1:0]             wiper_b,
  input  dp_cmd_t                         cmd,
  output dp_status_t                      status,
  output logic signed [POSITION_BITS-1:0] position,
  output logic [1:0]                      turn_direction,
  output logic                            moving
);

  localparam int WIDE_BITS = ((POSITION_BITS > ADC_BITS) ? POSITION_BITS : ADC_BITS) + 2;
  localparam int CNT_BITS  = $clog2(ADC_BITS + 1);
  localparam int SCL_BITS  = ADC_BITS + 3;

  // configuration registers
  logic [ADC_BITS-1:0]             move_threshold;
  logic [ADC_BITS-1:0]             adc_full_scale;
  logic [ADC_BITS-1:0]             step_divisor;
  logic signed [POSITION_BITS-1:0] position_floor;
  logic signed [POSITION_BITS-1:0] position_ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold   <= ADC_BITS'(THRESHOLD_RESET);
      adc_full_scale   <= ADC_BITS'(FULL_SCALE_RESET);
      step_divisor     <= ADC_BITS'(DIVISOR_RESET);
      position_floor   <= POSITION_BITS'(FLOOR_RESET);
      position_ceiling <= POSITION_BITS'(CEILING_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MOVE_THRESHOLD:   move_threshold   <= cfg_data[ADC_BITS-1:0];
        CFG_ADC_FULL_SCALE:   adc_full_scale   <= cfg_data[ADC_BITS-1:0];
        CFG_STEP_DIVISOR:     step_divisor     <= cfg_data[ADC_BITS-1:0];
        CFG_POSITION_FLOOR:   position_floor   <= cfg_data[POSITION_BITS-1:0];
        CFG_POSITION_CEILING: position_ceiling <= cfg_data[POSITION_BITS-1:0];
        default: ;
      endcase
    end
  end

  // tracker state
  logic [ADC_BITS-1:0]             last_wiper_a;
  logic [ADC_BITS-1:0]             last_wiper_b;
  logic signed [POSITION_BITS-1:0] knob_position;

  // captured sample and per-item work registers
  logic [ADC_BITS-1:0] cur_a;
  logic [ADC_BITS-1:0] cur_b;
  turn_dir_t           dir;
  logic [ADC_BITS-1:0] quo;
  logic [ADC_BITS:0]   rem;
  logic [ADC_BITS-1:0] divisor;
  logic [CNT_BITS-1:0] count;

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_a <= wiper_a;
      cur_b <= wiper_b;
    end
  end

  // movement classification against the dead band
  turn_dir_t          move_a, move_b, dir_next;
  logic [ADC_BITS-1:0] half;
  logic [SCL_BITS-1:0] a_x5;
  logic                a_in_band;
  logic [ADC_BITS-1:0] diff;

  function automatic turn_dir_t classify(input logic [ADC_BITS-1:0] now,
                                         input logic [ADC_BITS-1:0] prev,
                                         input logic [ADC_BITS-1:0] th);
    turn_dir_t res;
    res = DIR_NONE;
    if ({1'b0, now} > ({1'b0, prev} + {1'b0, th})) begin
      res = DIR_CW;
    end else if (({1'b0, now} + {1'b0, th}) < {1'b0, prev}) begin
      res = DIR_CCW;
    end
    return res;
  endfunction

  always_comb begin
    move_a = classify(cur_a, last_wiper_a, move_threshold);
    move_b = classify(cur_b, last_wiper_b, move_threshold);
    half   = adc_full_scale >> 1;
    // direction from both movements and the half-scale tests
    dir_next = DIR_NONE;
    if (move_a == DIR_CCW && move_b == DIR_CCW) begin
      dir_next = (cur_a > cur_b) ? DIR_CW : DIR_CCW;
    end else if (move_a == DIR_CW && move_b == DIR_CW) begin
      dir_next = (cur_a < cur_b) ? DIR_CW : DIR_CCW;
    end else if (move_a == DIR_CW && move_b == DIR_CCW) begin
      dir_next = (cur_a > half || cur_b > half) ? DIR_CW : DIR_CCW;
    end else if (move_a == DIR_CCW && move_b == DIR_CW) begin
      dir_next = (cur_a < half || cur_b < half) ? DIR_CW : DIR_CCW;
    end
    // wiper a usable between 20 and 80 percent of full scale
    a_x5      = {1'b0, cur_a, 2'b00} + SCL_BITS'(cur_a);
    a_in_band = (a_x5 < {1'b0, adc_full_scale, 2'b00}) &&
                (a_x5 > SCL_BITS'(adc_full_scale));
    if (a_in_band) begin
      diff = (cur_a >= last_wiper_a) ? (cur_a - last_wiper_a) : (last_wiper_a - cur_a);
    end else begin
      diff = (cur_b >= last_wiper_b) ? (cur_b - last_wiper_b) : (last_wiper_b - cur_b);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [ADC_BITS:0] shifted;
  always_comb begin
    shifted = {rem[ADC_BITS-1:0], quo[ADC_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dir     <= dir_next;
      quo     <= diff;
      rem     <= '0;
      count   <= '0;
      divisor <= (step_divisor == '0) ? ADC_BITS'(1) : step_divisor;
    end else if (cmd.div_step) begin
      count <= count + CNT_BITS'(1);
      if (shifted >= {1'b0, divisor}) begin
        rem <= shifted - {1'b0, divisor};
        quo <= {quo[ADC_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[ADC_BITS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    status.div_last = (count == CNT_BITS'(ADC_BITS - 1));
  end

  // step accumulation and clamping
  logic signed [WIDE_BITS-1:0]     sum;
  logic signed [POSITION_BITS-1:0] knob_next;
  always_comb begin
    if (dir == DIR_CW) begin
      sum = WIDE_BITS'(knob_position) + $signed({{(WIDE_BITS-ADC_BITS){1'b0}}, quo});
    end else begin
      sum = WIDE_BITS'(knob_position) - $signed({{(WIDE_BITS-ADC_BITS){1'b0}}, quo});
    end
    if (dir == DIR_NONE) begin
      knob_next = knob_position;
    end else if (sum < WIDE_BITS'(position_floor)) begin
      knob_next = position_floor;
    end else if (sum > WIDE_BITS'(position_ceiling)) begin
      knob_next = position_ceiling;
    end else begin
      knob_next = sum[POSITION_BITS-1:0];
    end
  end

  // tracker state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_wiper_a  <= '0;
      last_wiper_b  <= '0;
      knob_position <= '0;
    end else if (cmd.finish) begin
      last_wiper_a  <= cur_a;
      last_wiper_b  <= cur_b;
      knob_position <= knob_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      position       <= knob_next;
      turn_direction <= dir;
      moving         <= (dir != DIR_NONE);
    end
  end

  // remainder stays below the divisor while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < {1'b0, divisor}))
    else $error("divider remainder out of range");

  // moving flag agrees with the committed direction
  a_moving_dir: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (moving == (turn_direction != DIR_NONE)))
    else $error("moving flag disagrees with direction");

endmodule

[bench/tb_endless_pot_position_tracker_core.sv]
// testbench for the endless pot position tracker: random wiper walks checked against a knob model
`timescale 1ns / 100ps

module tb_endless_pot_position_tracker_core;
  import ept_pkg::*;

  localparam int ADC_W       = DEFAULT_ADC_BITS;
  localparam int POS_W       = DEFAULT_POSITION_BITS;
  localparam int CFG_W       = (ADC_W > POS_W) ? ADC_W : POS_W;
  localparam int SETTLE      = ADC_W + 8;
  localparam int LONG_HOLD   = 300;
  localparam int QUIET_LIMIT = 3000;

  typedef struct packed {
    logic [ADC_W-1:0] a;
    logic [ADC_W-1:0] b;
  } wiper_pair_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    turn_dir_t               dir;
    logic                    moving;
  } knob_report_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  ept_in_if  #(.ADC_BITS(ADC_W))      sample_if ();
  ept_out_if #(.POSITION_BITS(POS_W)) result_if ();

  endless_pot_position_tracker_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_if),
    .result_out (result_if)
  );

  always #5 clk = ~clk;

  // knob model: register copies and tracked state
  logic [ADC_W-1:0]        dead_band;
  logic [ADC_W-1:0]        full_scale;
  logic [ADC_W-1:0]        step_div;
  logic signed [POS_W-1:0] pos_floor;
  logic signed [POS_W-1:0] pos_ceil;
  logic [ADC_W-1:0]        last_a;
  logic [ADC_W-1:0]        last_b;
  logic signed [POS_W-1:0] knob;

  wiper_pair_t  queued_pairs[$];
  knob_report_t pending_reports[$];

  int  pairs_queued;
  int  pairs_sent;
  int  reports_checked;
  int  fail_count;
  int  turns_cw;
  int  turns_ccw;
  int  settings_done;
  int  walk_a;
  int  walk_b;
  int  tx_gap;
  int  rx_gap;
  int  hold_left;
  int  quiet_cycles;
  bit  calm;
  bit  hold_req;

  // movement of one wiper against the dead band
  function automatic turn_dir_t wiper_motion(int now_v, int prev_v, int band);
    if (now_v > prev_v + band) return DIR_CW;
    if (now_v < prev_v - band) return DIR_CCW;
    return DIR_NONE;
  endfunction

  // apply one sample pair to the knob state and return the report it causes
  function automatic knob_report_t advance_knob(logic [ADC_W-1:0] wa, logic [ADC_W-1:0] wb);
    int           a, b, pa, pb, fs, half, delta, divisor, p;
    turn_dir_t    mov_a, mov_b, dir;
    knob_report_t r;
    a     = wa;
    b     = wb;
    pa    = last_a;
    pb    = last_b;
    fs    = full_scale;
    half  = fs / 2;
    mov_a = wiper_motion(a, pa, dead_band);
    mov_b = wiper_motion(b, pb, dead_band);
    dir   = DIR_NONE;
    if (mov_a == DIR_CCW && mov_b == DIR_CCW) dir = (a > b) ? DIR_CW : DIR_CCW;
    else if (mov_a == DIR_CW && mov_b == DIR_CW) dir = (a < b) ? DIR_CW : DIR_CCW;
    else if (mov_a == DIR_CW && mov_b == DIR_CCW)
      dir = (a > half || b > half) ? DIR_CW : DIR_CCW;
    else if (mov_a == DIR_CCW && mov_b == DIR_CW)
      dir = (a < half || b < half) ? DIR_CW : DIR_CCW;
    if (dir != DIR_NONE) begin
      divisor = (step_div == 0) ? 1 : step_div;
      // wiper a is trusted only inside 20..80 percent of full scale
      if (5 * a < 4 * fs && 5 * a > fs) delta = a - pa;
      else delta = b - pb;
      if (delta < 0) delta = -delta;
      p = knob;
      if (dir == DIR_CW) p = p + delta / divisor;
      else p = p - delta / divisor;
      // when floor is above ceiling, results below the floor take the floor, all others the ceiling
      if (p < pos_floor) p = pos_floor;
      else if (p > pos_ceil) p = pos_ceil;
      knob = POS_W'(p);
    end
    last_a     = wa;
    last_b     = wb;
    r.position = knob;
    r.dir      = dir;
    r.moving   = (dir != DIR_NONE);
    return r;
  endfunction

  // random step of one wiper, clipped to zero and the given upper bound
  function automatic int nudge(int v, int mag, int hi);
    int n;
    n = ($urandom_range(0, 1) != 0) ? v + mag : v - mag;
    if (n < 0) n = 0;
    if (n > hi) n = hi;
    return n;
  endfunction

  task automatic push_pair(int a, int b);
    wiper_pair_t p;
    p.a = ADC_W'(a);
    p.b = ADC_W'(b);
    queued_pairs.push_back(p);
    pairs_queued++;
  endtask

  // mostly wiper walks that leave the dead band, some jitter and some wild samples
  task automatic queue_walk(int count);
    int hi;
    hi = (full_scale == 0) ? 4095 : full_scale;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          walk_a = $urandom_range(0, 4095);
          walk_b = $urandom_range(0, 4095);
        end
        1: begin
          walk_a = nudge(walk_a, $urandom_range(0, dead_band), hi);
          walk_b = nudge(walk_b, $urandom_range(0, dead_band), hi);
        end
        default: begin
          walk_a = nudge(walk_a, dead_band + $urandom_range(1, 300), hi);
          walk_b = nudge(walk_b, dead_band + $urandom_range(1, 300), hi);
        end
      endcase
      push_pair(walk_a, walk_b);
    end
  endtask

  // wait for every sample to be taken and every report to come back
  task automatic wait_drained;
    while (pairs_sent != pairs_queued || pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_MOVE_THRESHOLD:   dead_band  = data[ADC_W-1:0];
      CFG_ADC_FULL_SCALE:   full_scale = data[ADC_W-1:0];
      CFG_STEP_DIVISOR:     step_div   = data[ADC_W-1:0];
      CFG_POSITION_FLOOR:   pos_floor  = data[POS_W-1:0];
      CFG_POSITION_CEILING: pos_ceil   = data[POS_W-1:0];
      default: ;
    endcase
  endtask

  // drain, then write all registers; unused upper bits and unmapped indexes carry noise
  task automatic apply_settings(int band, int scale, int divisor, int lo, int hi);
    int idx;
    wait_drained;
    write_reg(CFG_MOVE_THRESHOLD, {4'($urandom_range(0, 15)), ADC_W'(band)});
    write_reg(CFG_ADC_FULL_SCALE, {4'($urandom_range(0, 15)), ADC_W'(scale)});
    write_reg(CFG_STEP_DIVISOR,   {4'($urandom_range(0, 15)), ADC_W'(divisor)});
    write_reg(CFG_POSITION_FLOOR,   POS_W'(lo));
    write_reg(CFG_POSITION_CEILING, POS_W'(hi));
    for (idx = CFG_POSITION_CEILING + 1; idx < 2 ** CFG_INDEX_BITS; idx++)
      write_reg(CFG_INDEX_BITS'(idx), CFG_W'($urandom));
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_done++;
  endtask

  // sample driver
  always @(posedge clk) begin : drive_samples
    wiper_pair_t next_pair;
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        pending_reports.push_back(advance_knob(sample_if.wiper_a, sample_if.wiper_b));
        pairs_sent++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          sample_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
          tx_gap = $urandom_range(0, 10);
          sample_if.valid <= 1'b0;
        end else if (queued_pairs.size() != 0) begin
          next_pair = queued_pairs.pop_front();
          sample_if.valid   <= 1'b1;
          sample_if.wiper_a <= next_pair.a;
          sample_if.wiper_b <= next_pair.b;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // report checker and receiver stalls
  always @(posedge clk) begin : check_reports
    knob_report_t want;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        reports_checked++;
        if (pending_reports.size() == 0) begin
          $error("report with no sample pending: position %0d", result_if.position);
          fail_count++;
        end else begin
          want = pending_reports.pop_front();
          if (want.dir == DIR_CW) turns_cw++;
          if (want.dir == DIR_CCW) turns_ccw++;
          if (result_if.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, result_if.position);
            fail_count++;
          end
          if (result_if.turn_direction !== want.dir) begin
            $error("turn_direction: expected %0d, got %0d", want.dir,
                   result_if.turn_direction);
            fail_count++;
          end
          if (result_if.moving !== want.moving) begin
            $error("moving: expected %0d, got %0d", want.moving, result_if.moving);
            fail_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        result_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 10);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run_phases
    int lo_v;
    int hi_v;
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    sample_if.valid   = 1'b0;
    sample_if.wiper_a = '0;
    sample_if.wiper_b = '0;
    result_if.ready   = 1'b0;
    dead_band         = THRESHOLD_RESET;
    full_scale        = FULL_SCALE_RESET;
    step_div          = DIVISOR_RESET;
    pos_floor         = FLOOR_RESET;
    pos_ceil          = CEILING_RESET;
    last_a            = '0;
    last_b            = '0;
    knob              = '0;
    calm              = 1'b0;
    hold_req          = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: no move, both directions of every wiper combination
    push_pair(0, 0);
    push_pair(300, 400);
    push_pair(310, 410);      // exactly on the dead band edge
    push_pair(600, 500);
    push_pair(400, 300);
    push_pair(200, 350);      // wiper a below 20 percent, step from b
    push_pair(700, 100);
    push_pair(800, 50);
    push_pair(900, 10);       // wiper a above 80 percent
    push_pair(100, 300);
    push_pair(200, 250);
    push_pair(900, 600);
    push_pair(800, 700);
    push_pair(1000, 4095);    // big step into the ceiling
    push_pair(0, 0);          // big step into the floor
    push_pair(2730, 1365);
    push_pair(1365, 2730);
    push_pair(4095, 0);
    push_pair(0, 4095);

    // zero dead band, zero divisor, scale boundaries at exactly 20 and 80 percent
    apply_settings(0, 1000, 0, -32768, 32767);
    push_pair(200, 3000);
    push_pair(800, 3100);
    push_pair(500, 3200);     // wiper a exactly at half scale
    push_pair(600, 500);
    push_pair(500, 500);
    push_pair(501, 499);
    walk_a = 500;
    walk_b = 500;

    // widest range
    apply_settings(0, 4095, 1, -32768, 32767);
    queue_walk(100);

    // dead band too wide to ever move, floor above ceiling
    apply_settings(4095, 1, 4095, 32767, -32768);
    queue_walk(40);

    // floor above ceiling with movement
    apply_settings(3, 200, 2, 50, -50);
    queue_walk(80);

    // long receiver hold so the block backs up into its input
    apply_settings(10, 1023, 0, -100, 100);
    hold_req = 1'b1;
    queue_walk(110);

    // zero full scale
    apply_settings(5, 0, 7, -500, 500);
    queue_walk(60);

    repeat (3) begin
      lo_v = int'($urandom_range(0, 3000)) - 1500;
      hi_v = lo_v + int'($urandom_range(0, 3000));
      apply_settings($urandom_range(0, 40), $urandom_range(1, 4095),
                     $urandom_range(1, 20), lo_v, hi_v);
      queue_walk(80);
    end

    // closing stretch at full rate on both sides
    apply_settings(THRESHOLD_RESET, FULL_SCALE_RESET, DIVISOR_RESET, FLOOR_RESET,
                   CEILING_RESET);
    calm = 1'b1;
    queue_walk(100);
    wait_drained;

    if (pending_reports.size() != 0) begin
      $error("%0d reports never arrived", pending_reports.size());
      fail_count++;
    end
    $display("covered %0d sample pairs over %0d register settings, %0d reports checked",
             pairs_sent, settings_done, reports_checked);
    $display("turns seen: %0d clockwise, %0d counter-clockwise", turns_cw, turns_ccw);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
